// ===== rtl/vnf_pkg.sv =====
// Shared types, codes and step tables for the voxel neighbourhood filter.
// No dependencies; every other file but vnf_ram imports this package.
package vnf_pkg;

	localparam int CW     = 6;   // coordinate field width
	localparam int NW     = 7;   // neighbour coordinate / extent width
	localparam int SW     = 7;   // size register width
	localparam int MW     = 3;   // filter mode width
	localparam int CODEW  = 8;   // corner code width
	localparam int STEPS  = 8;   // most reads for one query
	localparam int STW    = 3;   // step counter width
	localparam int IXW    = 3;   // config index width
	localparam int QDEPTH = 2;   // front to back queue depth
	localparam int QAW    = 1;

	localparam logic [SW-1:0] SIZE_RESET = 7'd64;

	localparam logic [IXW-1:0] REG_SIZE_I      = 3'd0;
	localparam logic [IXW-1:0] REG_SIZE_J      = 3'd1;
	localparam logic [IXW-1:0] REG_SIZE_K      = 3'd2;
	localparam logic [IXW-1:0] REG_FILTER_MODE = 3'd3;

	localparam logic [MW-1:0] MODE_COPY   = 3'd0;
	localparam logic [MW-1:0] MODE_EDGE   = 3'd1;
	localparam logic [MW-1:0] MODE_WIRE   = 3'd2;
	localparam logic [MW-1:0] MODE_HOLLOW = 3'd3;
	localparam logic [MW-1:0] MODE_JLINE  = 3'd4;
	localparam logic [MW-1:0] MODE_CORNER = 3'd5;
	localparam logic [MW-1:0] MODE_SOLID  = 3'd6;

	localparam logic CMD_WRITE = 1'b0;

	typedef enum logic [3:0] {
		OP_WRITE,
		OP_OOR,
		OP_COPY,
		OP_EDGE,
		OP_WIRE,
		OP_HOLLOW,
		OP_JLINE,
		OP_CORNER,
		OP_SOLID
	} op_t;

	typedef enum logic [1:0] {
		D_ZERO,
		D_MINUS,
		D_PLUS
	} delta_t;

	typedef struct packed {
		delta_t di;
		delta_t dj;
		delta_t dk;
	} offs_t;

	typedef struct packed {
		op_t           op;
		logic [CW-1:0] ci;
		logic [CW-1:0] cj;
		logic [CW-1:0] ck;
		logic          wbit;
	} item_t;

	typedef struct packed {
		logic [NW-1:0] ei;
		logic [NW-1:0] ej;
		logic [NW-1:0] ek;
	} ext_t;

	typedef enum logic [1:0] {
		B_IDLE,
		B_READ,
		B_WAIT,
		B_FIN
	} bstate_t;

	// index of the final read step for each operation
	function automatic logic [STW-1:0] last_step(op_t op);
		logic [STW-1:0] n;
		n = '0;
		case (op)
			OP_EDGE, OP_CORNER: n = 3'd7;
			OP_WIRE, OP_HOLLOW: n = 3'd6;
			OP_JLINE:           n = 3'd2;
			default:            n = '0;
		endcase
		return n;
	endfunction

	// step 0 is always the voxel itself
	function automatic offs_t step_offs(op_t op, logic [STW-1:0] s);
		offs_t o;
		o = '{di: D_ZERO, dj: D_ZERO, dk: D_ZERO};
		case (op)
			OP_EDGE: begin
				o.di = s[0] ? D_MINUS : D_ZERO;
				o.dj = s[1] ? D_MINUS : D_ZERO;
				o.dk = s[2] ? D_MINUS : D_ZERO;
			end
			OP_CORNER: begin
				o.di = s[0] ? D_PLUS : D_ZERO;
				o.dj = s[1] ? D_PLUS : D_ZERO;
				o.dk = s[2] ? D_PLUS : D_ZERO;
			end
			OP_WIRE, OP_HOLLOW: begin
				case (s)
					3'd1:    o.di = D_MINUS;
					3'd2:    o.di = D_PLUS;
					3'd3:    o.dj = D_MINUS;
					3'd4:    o.dj = D_PLUS;
					3'd5:    o.dk = D_MINUS;
					3'd6:    o.dk = D_PLUS;
					default: ;
				endcase
			end
			OP_JLINE: begin
				case (s)
					3'd1:    o.dj = D_MINUS;
					3'd2:    o.dj = D_PLUS;
					default: ;
				endcase
			end
			default: ;
		endcase
		return o;
	endfunction

endpackage

// ===== rtl/vnf_if.sv =====
// Valid/ready channel interfaces: input items, results and config writes.
// Depends on vnf_pkg for field widths.
interface vnf_item_if import vnf_pkg::*; ();
	logic          valid;
	logic          ready;
	logic          cmd;
	logic [CW-1:0] coord_i;
	logic [CW-1:0] coord_j;
	logic [CW-1:0] coord_k;
	logic          write_bit;
	logic          block_selected;

	modport source (output valid, cmd, coord_i, coord_j, coord_k, write_bit,
		block_selected, input ready);
	modport sink (input valid, cmd, coord_i, coord_j, coord_k, write_bit,
		block_selected, output ready);
endinterface

interface vnf_result_if import vnf_pkg::*; ();
	logic             valid;
	logic             ready;
	logic             filtered_bit;
	logic [CODEW-1:0] corner_code;
	logic             out_of_range;

	modport source (output valid, filtered_bit, corner_code, out_of_range, input ready);
	modport sink (input valid, filtered_bit, corner_code, out_of_range, output ready);
endinterface

interface vnf_cfg_if import vnf_pkg::*; ();
	logic           valid;
	logic           ready;
	logic [IXW-1:0] index;
	logic [SW-1:0]  data;

	modport source (output valid, index, data, input ready);
	modport sink (input valid, index, data, output ready);
endinterface

// ===== rtl/voxel_neighbor_filter_3d.sv =====
// Binary voxel volume with 3D neighbourhood filter, top level.
// Depends on vnf_pkg, vnf_if, vnf_front, vnf_queue and vnf_back.
//
// Channels: item (write or query beats), result (one beat per item) and cfg
// (register writes, always ready). Config must only change while idle.
// A write stores one bit of a single-port MAX_I*MAX_J*MAX_K voxel store; a
// query reads the voxel and the neighbours its filter mode needs, one store
// read per cycle.
// In the back end a write or out of range item is dequeued and its result
// loaded in the same cycle; a query is dequeued, makes its store reads
// (copy or solid 1, j-line 3, wire or hollow 7, edge or corner 8), waits
// for the last read data and loads its result. Items first pass the queue.
// The front end takes items into a two-deep queue while the back end works,
// so up to two items wait behind the one in progress.
// A stalled result is held in the output register; the back end then waits
// with its finished result and the queue fills before item.ready drops.
// Reset clears control state and sets the sizes to 64 and the mode to copy;
// the store is not cleared and must be written before it is read.
module voxel_neighbor_filter_3d import vnf_pkg::*; #(
	parameter int MAX_I = 64,
	parameter int MAX_J = 64,
	parameter int MAX_K = 64
) (
	input  logic         clk,
	input  logic         arst_n,
	vnf_item_if.sink     item,
	vnf_result_if.source result,
	vnf_cfg_if.sink      cfg
);

	logic  push, q_full, q_pop, q_valid;
	item_t push_item, q_item;
	ext_t  ext;

	vnf_front #(.MAX_I(MAX_I), .MAX_J(MAX_J), .MAX_K(MAX_K)) u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.item      (item),
		.cfg       (cfg),
		.q_full    (q_full),
		.push      (push),
		.push_item (push_item),
		.ext       (ext)
	);

	vnf_queue u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.push_item (push_item),
		.full      (q_full),
		.pop       (q_pop),
		.valid     (q_valid),
		.head      (q_item)
	);

	vnf_back #(.MAX_I(MAX_I), .MAX_J(MAX_J), .MAX_K(MAX_K)) u_back (
		.clk     (clk),
		.arst_n  (arst_n),
		.q_valid (q_valid),
		.q_item  (q_item),
		.q_pop   (q_pop),
		.ext     (ext),
		.result  (result)
	);

	a_pop_nonempty: assert property (@(posedge clk) disable iff (!arst_n)
		q_pop |-> q_valid)
		else $error("queue popped while empty");

	a_direct_room: assert property (@(posedge clk) disable iff (!arst_n)
		q_pop && (q_item.op == OP_WRITE || q_item.op == OP_OOR) |->
		(!result.valid || result.ready))
		else $error("direct result would overwrite a held result");

	a_query_busy: assert property (@(posedge clk) disable iff (!arst_n)
		q_pop && !(q_item.op == OP_WRITE || q_item.op == OP_OOR) |=> !q_pop)
		else $error("dequeue while a query is in progress");

endmodule

// ===== rtl/vnf_ram.sv =====
// Generic single-port RAM, registered read.
// No dependencies.
module vnf_ram #(
	parameter int W     = 1,
	parameter int DEPTH = 64,
	localparam int AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  logic          clk,
	input  logic          en,
	input  logic          we,
	input  logic [AW-1:0] addr,
	input  logic [W-1:0]  wdata,
	output logic [W-1:0]  rdata
);

	logic [W-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (en) begin
			if (we) begin
				mem[addr] <= wdata;
			end else begin
				rdata <= mem[addr];
			end
		end
	end

endmodule

// ===== rtl/vnf_front.sv =====
// Front end: config registers, extent saturation, range check and
// classification of each input beat into an operation for the back end.
// Depends on vnf_pkg and vnf_if.
module vnf_front import vnf_pkg::*; #(
	parameter int MAX_I = 64,
	parameter int MAX_J = 64,
	parameter int MAX_K = 64
) (
	input  logic       clk,
	input  logic       arst_n,
	vnf_item_if.sink   item,
	vnf_cfg_if.sink    cfg,
	input  logic       q_full,
	output logic       push,
	output item_t      push_item,
	output ext_t       ext
);

	logic [SW-1:0] size_i_q, size_j_q, size_k_q;
	logic [MW-1:0] mode_q;
	logic          oor;

	assign cfg.ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			size_i_q <= SIZE_RESET;
			size_j_q <= SIZE_RESET;
			size_k_q <= SIZE_RESET;
			mode_q   <= MODE_COPY;
		end else if (cfg.valid && cfg.ready) begin
			case (cfg.index)
				REG_SIZE_I:      size_i_q <= cfg.data;
				REG_SIZE_J:      size_j_q <= cfg.data;
				REG_SIZE_K:      size_k_q <= cfg.data;
				REG_FILTER_MODE: mode_q   <= cfg.data[MW-1:0];
				default: ;
			endcase
		end
	end

	// extent in effect never exceeds the store
	always_comb begin
		ext.ei = (32'(size_i_q) > MAX_I) ? NW'(MAX_I) : size_i_q;
		ext.ej = (32'(size_j_q) > MAX_J) ? NW'(MAX_J) : size_j_q;
		ext.ek = (32'(size_k_q) > MAX_K) ? NW'(MAX_K) : size_k_q;
	end

	assign oor = ({1'b0, item.coord_i} >= ext.ei) || ({1'b0, item.coord_j} >= ext.ej) ||
		({1'b0, item.coord_k} >= ext.ek);

	assign item.ready = !q_full;
	assign push       = item.valid && !q_full;

	always_comb begin
		push_item.ci   = item.coord_i;
		push_item.cj   = item.coord_j;
		push_item.ck   = item.coord_k;
		push_item.wbit = item.write_bit;
		push_item.op   = OP_COPY;
		if (oor) begin
			push_item.op = OP_OOR;
		end else if (item.cmd == CMD_WRITE) begin
			push_item.op = OP_WRITE;
		end else begin
			case (mode_q)
				MODE_EDGE:   push_item.op = item.block_selected ? OP_EDGE : OP_COPY;
				MODE_WIRE:   push_item.op = item.block_selected ? OP_WIRE : OP_COPY;
				MODE_HOLLOW: push_item.op = item.block_selected ? OP_HOLLOW : OP_COPY;
				MODE_JLINE:  push_item.op = OP_JLINE;
				MODE_CORNER: push_item.op = OP_CORNER;
				MODE_SOLID:  push_item.op = OP_SOLID;
				default:     push_item.op = OP_COPY;
			endcase
		end
	end

endmodule

// ===== rtl/vnf_queue.sv =====
// Short FIFO of classified operations between front and back ends.
// Depends on vnf_pkg.
module vnf_queue import vnf_pkg::*; (
	input  logic  clk,
	input  logic  arst_n,
	input  logic  push,
	input  item_t push_item,
	output logic  full,
	input  logic  pop,
	output logic  valid,
	output item_t head
);

	item_t          ent_q [QDEPTH];
	logic [QAW-1:0] wp_q, rp_q;
	logic [QAW:0]   cnt_q;

	assign full  = (cnt_q == (QAW+1)'(QDEPTH));
	assign valid = (cnt_q != '0);
	assign head  = ent_q[rp_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q  <= '0;
			rp_q  <= '0;
			cnt_q <= '0;
		end else begin
			if (push) begin
				wp_q <= (wp_q == QAW'(QDEPTH-1)) ? '0 : wp_q + 1'b1;
			end
			if (pop) begin
				rp_q <= (rp_q == QAW'(QDEPTH-1)) ? '0 : rp_q + 1'b1;
			end
			case ({push, pop})
				2'b10:   cnt_q <= cnt_q + 1'b1;
				2'b01:   cnt_q <= cnt_q - 1'b1;
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			ent_q[wp_q] <= push_item;
		end
	end

endmodule

// ===== rtl/vnf_back.sv =====
// Back end: writes the voxel store, sequences its reads for each query,
// one per cycle, evaluates the filter and holds the result register.
// Depends on vnf_pkg, vnf_if and vnf_ram.
module vnf_back import vnf_pkg::*; #(
	parameter int MAX_I = 64,
	parameter int MAX_J = 64,
	parameter int MAX_K = 64
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        q_valid,
	input  item_t       q_item,
	output logic        q_pop,
	input  ext_t        ext,
	vnf_result_if.source result
);

	localparam int DEPTH = MAX_I * MAX_J * MAX_K;
	localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;

	typedef struct packed {
		logic          ok;
		logic [NW-1:0] c;
	} ncoord_t;

	typedef struct packed {
		logic             fb;
		logic [CODEW-1:0] code;
		logic             oor;
	} res_t;

	function automatic logic [AW-1:0] addr_of(logic [NW-1:0] i, logic [NW-1:0] j,
		logic [NW-1:0] k);
		return AW'(k) + AW'(MAX_K) * (AW'(j) + AW'(MAX_J) * AW'(i));
	endfunction

	function automatic ncoord_t shift_coord(logic [CW-1:0] c, delta_t d, logic [NW-1:0] e);
		ncoord_t r;
		r.c  = {1'b0, c};
		r.ok = 1'b1;
		case (d)
			D_MINUS: begin
				r.ok = (c != '0);
				r.c  = {1'b0, c} - 1'b1;
			end
			D_PLUS:  r.c = {1'b0, c} + 1'b1;
			default: ;
		endcase
		r.ok = r.ok && (r.c < e);
		return r;
	endfunction

	function automatic res_t evaluate(op_t op, logic [STEPS-1:0] nb, logic [STEPS-1:0] vld);
		logic       v;
		logic [1:0] empties;
		res_t       r;
		v       = nb[0];
		empties = 2'(!(nb[1] | nb[2])) + 2'(!(nb[3] | nb[4])) + 2'(!(nb[5] | nb[6]));
		r.fb    = v;
		r.code  = '0;
		r.oor   = 1'b0;
		case (op)
			OP_EDGE:   r.fb = |((nb ^ {STEPS{v}}) & vld);
			OP_WIRE:   if (empties == 2'd1) r.fb = 1'b0;
			OP_HOLLOW: if (&nb[6:1]) r.fb = 1'b0;
			OP_JLINE:  if (nb[1] == nb[2]) r.fb = 1'b0;  // count of 0 or 2
			OP_CORNER: r.code = nb;
			OP_SOLID:  r.code = {CODEW{v}};
			default: ;
		endcase
		return r;
	endfunction

	bstate_t          state_q, state_d;
	op_t              op_q;
	logic [CW-1:0]    ci_q, cj_q, ck_q;
	logic [STW-1:0]   step_q;
	logic [STEPS-1:0] nb_q, vld_q;
	logic             pend_s1, vld_s1;
	logic [STW-1:0]   step_s1;
	logic             res_valid_q;
	res_t             res_q, res_d;

	logic             out_free, load_work, res_load, rd_ok, is_direct;
	logic             mem_en, mem_we;
	logic [AW-1:0]    mem_addr, rd_addr, wr_addr;
	logic [0:0]       mem_wdata, mem_rdata;
	offs_t            offs;
	ncoord_t          ni, nj, nk;

	vnf_ram #(.W(1), .DEPTH(DEPTH)) u_ram (
		.clk   (clk),
		.en    (mem_en),
		.we    (mem_we),
		.addr  (mem_addr),
		.wdata (mem_wdata),
		.rdata (mem_rdata)
	);

	assign offs    = step_offs(op_q, step_q);
	assign ni      = shift_coord(ci_q, offs.di, ext.ei);
	assign nj      = shift_coord(cj_q, offs.dj, ext.ej);
	assign nk      = shift_coord(ck_q, offs.dk, ext.ek);
	assign rd_ok   = ni.ok && nj.ok && nk.ok;
	assign rd_addr = addr_of(ni.c, nj.c, nk.c);
	assign wr_addr = addr_of({1'b0, q_item.ci}, {1'b0, q_item.cj}, {1'b0, q_item.ck});
	assign mem_wdata = q_item.wbit;

	assign out_free  = !res_valid_q || result.ready;
	assign is_direct = (q_item.op == OP_WRITE) || (q_item.op == OP_OOR);

	always_comb begin
		state_d   = state_q;
		q_pop     = 1'b0;
		mem_en    = 1'b0;
		mem_we    = 1'b0;
		mem_addr  = rd_addr;
		load_work = 1'b0;
		res_load  = 1'b0;
		case (state_q)
			B_IDLE: begin
				if (q_valid) begin
					if (is_direct) begin
						if (out_free) begin
							q_pop    = 1'b1;
							res_load = 1'b1;
							if (q_item.op == OP_WRITE) begin
								mem_en   = 1'b1;
								mem_we   = 1'b1;
								mem_addr = wr_addr;
							end
						end
					end else begin
						q_pop     = 1'b1;
						load_work = 1'b1;
						state_d   = B_READ;
					end
				end
			end
			B_READ: begin
				mem_en = rd_ok;
				if (step_q == last_step(op_q)) begin
					state_d = B_WAIT;
				end
			end
			B_WAIT: state_d = B_FIN;  // last read data lands this cycle
			B_FIN: begin
				if (out_free) begin
					res_load = 1'b1;
					state_d  = B_IDLE;
				end
			end
			default: state_d = B_IDLE;
		endcase
	end

	always_comb begin
		if (state_q == B_FIN) begin
			res_d = evaluate(op_q, nb_q, vld_q);
		end else begin
			res_d.fb   = 1'b0;
			res_d.code = '0;
			res_d.oor  = (q_item.op == OP_OOR);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= B_IDLE;
			pend_s1     <= 1'b0;
			res_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			pend_s1 <= (state_q == B_READ);
			if (res_load) begin
				res_valid_q <= 1'b1;
			end else if (result.ready) begin
				res_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (load_work) begin
			op_q   <= q_item.op;
			ci_q   <= q_item.ci;
			cj_q   <= q_item.cj;
			ck_q   <= q_item.ck;
			step_q <= '0;
		end else if (state_q == B_READ) begin
			step_q <= step_q + 1'b1;
		end
		step_s1 <= step_q;
		vld_s1  <= rd_ok;
		// reads outside the volume land as zero
		if (pend_s1) begin
			nb_q[step_s1]  <= mem_rdata[0] & vld_s1;
			vld_q[step_s1] <= vld_s1;
		end
		if (res_load) begin
			res_q <= res_d;
		end
	end

	assign result.valid        = res_valid_q;
	assign result.filtered_bit = res_q.fb;
	assign result.corner_code  = res_q.code;
	assign result.out_of_range = res_q.oor;

endmodule
